### design/fsla_pkg.sv
package fsla_pkg;

    localparam int SLOT_W = 8;
    localparam int STS_W  = 2;

    localparam logic [SLOT_W-1:0] END_MARK = 8'hFF;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [STS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL     = 2'd1;
    localparam logic [STS_W-1:0] STS_BAD_SLOT = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_ALLOC_RD
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic rd_en;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_alloc;
        logic alloc_ok;
        logic out_busy;
    } t_sts;

endpackage

### design/fsla_req_if.sv
interface fsla_req_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [fsla_pkg::SLOT_W-1:0]   slot_in;

    modport source (output valid, output kind, output slot_in, input ready);
    modport sink (input valid, input kind, input slot_in, output ready);
endinterface

### design/fsla_rsp_if.sv
interface fsla_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fsla_pkg::SLOT_W-1:0]   slot_out;
    logic [fsla_pkg::STS_W-1:0]    status;
    logic [fsla_pkg::SLOT_W-1:0]   occupied;

    modport source (output valid, output slot_out, output status, output occupied,
                    input ready);
    modport sink (input valid, input slot_out, input status, input occupied,
                  output ready);
endinterface

### design/free_list_slot_allocator.sv
// Free-list slot allocator.
// Request channel i_req carries kind (0 allocate, 1 release) and slot_in.
// Response channel o_rsp carries slot_out, status (0 ok, 1 full, 2 bad
// slot) and occupied, one response per request, in order.
// i_cfg_wr_en/i_cfg_wr_data set the slot count (clamped to 1..MAX_SLOTS)
// and rebuild the free chain: head 0, count 0, slot i linked to i+1.
// A release or a failed allocate is captured, then executed, and its
// response registered; a successful allocate also reads its link in
// S_ALLOC_RD, since the link table is a memory with a registered read
// port. A new request is taken only once the last one has finished.
// Reset (synchronous, active low) sets the slot count to MAX_SLOTS and
// rebuilds the chain at once; per-entry valid bits make unwritten links
// read as the rebuilt chain, so no clearing pass is needed.
// The response sits in an output register; while the receiver stalls the
// block still takes the next request but holds its update until the
// register frees up.
module free_list_slot_allocator #(
    parameter int MAX_SLOTS = 254
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [fsla_pkg::SLOT_W-1:0]   i_cfg_wr_data,
    fsla_req_if.sink                      i_req,
    fsla_rsp_if.source                    o_rsp
);

    fsla_pkg::t_cmd w_cmd;
    fsla_pkg::t_sts w_sts;

    fsla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    fsla_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_kind        (i_req.kind),
        .i_slot_in     (i_req.slot_in),
        .i_out_ready   (o_rsp.ready),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (o_rsp.valid),
        .o_slot_out    (o_rsp.slot_out),
        .o_status      (o_rsp.status),
        .o_occupied    (o_rsp.occupied)
    );

    assign i_req.ready = w_cmd.in_ready;

endmodule

### design/fsla_ctrl.sv
module fsla_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  fsla_pkg::t_sts   i_sts,
    output fsla_pkg::t_cmd   o_cmd
);

    fsla_pkg::t_state r_state;
    fsla_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsla_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fsla_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = fsla_pkg::S_EXEC;
                end
            end
            fsla_pkg::S_EXEC: begin
                if (i_sts.is_alloc && i_sts.alloc_ok) begin
                    n_state = fsla_pkg::S_ALLOC_RD;
                end else if (!i_sts.out_busy) begin
                    n_state = fsla_pkg::S_IDLE;
                end
            end
            fsla_pkg::S_ALLOC_RD: begin
                if (!i_sts.out_busy) begin
                    n_state = fsla_pkg::S_IDLE;
                end
            end
            default: n_state = fsla_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            fsla_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.capture  = i_in_valid;
            end
            fsla_pkg::S_EXEC: begin
                if (i_sts.is_alloc && i_sts.alloc_ok) begin
                    o_cmd.rd_en = 1'b1;
                end else begin
                    o_cmd.finish = !i_sts.out_busy;
                end
            end
            fsla_pkg::S_ALLOC_RD: begin
                o_cmd.finish = !i_sts.out_busy;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

### design/fsla_dp.sv
module fsla_dp #(
    parameter int MAX_SLOTS = 254
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [fsla_pkg::SLOT_W-1:0]   i_cfg_wr_data,
    input  logic                          i_kind,
    input  logic [fsla_pkg::SLOT_W-1:0]   i_slot_in,
    input  logic                          i_out_ready,
    input  fsla_pkg::t_cmd                i_cmd,
    output fsla_pkg::t_sts                o_sts,
    output logic                          o_out_valid,
    output logic [fsla_pkg::SLOT_W-1:0]   o_slot_out,
    output logic [fsla_pkg::STS_W-1:0]    o_status,
    output logic [fsla_pkg::SLOT_W-1:0]   o_occupied
);

    localparam int ADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam logic [fsla_pkg::SLOT_W-1:0] MAX_CNT = fsla_pkg::SLOT_W'(MAX_SLOTS);

    logic [fsla_pkg::SLOT_W-1:0] r_mem [MAX_SLOTS];
    logic                        r_vld [MAX_SLOTS];

    logic [fsla_pkg::SLOT_W-1:0] r_slot_cnt;
    logic [fsla_pkg::SLOT_W-1:0] r_head;
    logic [fsla_pkg::SLOT_W-1:0] r_used;
    logic                        r_kind;
    logic [fsla_pkg::SLOT_W-1:0] r_slot;
    logic [fsla_pkg::SLOT_W-1:0] r_rd_data;
    logic                        r_rd_vld;
    logic                        r_out_vld;
    logic [fsla_pkg::SLOT_W-1:0] r_out_slot;
    logic [fsla_pkg::STS_W-1:0]  r_out_sts;

    logic [fsla_pkg::SLOT_W-1:0] n_cfg_cnt;
    logic [fsla_pkg::SLOT_W-1:0] n_link;
    logic                        n_alloc_ok;
    logic                        n_rel_ok;
    logic                        n_wr_en;

    always_comb begin
        n_cfg_cnt = i_cfg_wr_data;
        if (i_cfg_wr_data == '0) begin
            n_cfg_cnt = fsla_pkg::SLOT_W'(1);
        end else if (i_cfg_wr_data > MAX_CNT) begin
            n_cfg_cnt = MAX_CNT;
        end
    end

    // unwritten entries still hold the rebuilt chain
    always_comb begin
        if (r_rd_vld) begin
            n_link = r_rd_data;
        end else if (r_head == r_slot_cnt - fsla_pkg::SLOT_W'(1)) begin
            n_link = fsla_pkg::END_MARK;
        end else begin
            n_link = r_head + fsla_pkg::SLOT_W'(1);
        end
    end

    assign n_alloc_ok = (r_head < r_slot_cnt);
    assign n_rel_ok   = (r_slot < r_slot_cnt);
    assign n_wr_en    = i_cmd.finish && (r_kind == fsla_pkg::KIND_RELEASE) && n_rel_ok;

    assign o_sts.is_alloc = (r_kind == fsla_pkg::KIND_ALLOC);
    assign o_sts.alloc_ok = n_alloc_ok;
    assign o_sts.out_busy = r_out_vld && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_mem[r_slot[ADDR_W-1:0]] <= r_head;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_head[ADDR_W-1:0]];
            r_rd_vld  <= r_vld[r_head[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (n_wr_en) begin
            r_vld[r_slot[ADDR_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_slot <= i_slot_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_cnt <= MAX_CNT;
            r_head     <= '0;
            r_used     <= '0;
            r_out_vld  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_slot_cnt <= n_cfg_cnt;
            r_head     <= '0;
            r_used     <= '0;
        end else begin
            if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_out_vld  <= 1'b1;
                r_out_slot <= '0;
                r_out_sts  <= fsla_pkg::STS_OK;
                if (r_kind == fsla_pkg::KIND_ALLOC) begin
                    if (n_alloc_ok) begin
                        r_out_slot <= r_head;
                        r_head     <= n_link;
                        if (r_used < r_slot_cnt) begin
                            r_used <= r_used + fsla_pkg::SLOT_W'(1);
                        end
                    end else begin
                        r_out_sts <= fsla_pkg::STS_FULL;
                    end
                end else begin
                    if (n_rel_ok) begin
                        r_head <= r_slot;
                        if (r_used != '0) begin
                            r_used <= r_used - fsla_pkg::SLOT_W'(1);
                        end
                    end else begin
                        r_out_sts <= fsla_pkg::STS_BAD_SLOT;
                    end
                end
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_slot_out  = r_out_slot;
    assign o_status    = r_out_sts;
    assign o_occupied  = r_used;

endmodule

### design/fsla_chk.sv
module fsla_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [fsla_pkg::SLOT_W-1:0]   i_slot_out,
    input  logic [fsla_pkg::STS_W-1:0]    i_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response dropped while stalled");

    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while one is in flight");

    a_sts_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == fsla_pkg::STS_OK || i_status == fsla_pkg::STS_FULL
                         || i_status == fsla_pkg::STS_BAD_SLOT))
        else $error("illegal status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != fsla_pkg::STS_OK |-> i_slot_out == '0)
        else $error("failed request returned a slot");

endmodule

bind free_list_slot_allocator fsla_chk u_fsla_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_slot_out  (o_rsp.slot_out),
    .i_status    (o_rsp.status)
);

### test/tb_free_list_slot_allocator.sv
`timescale 1ns / 1ps

module tb_free_list_slot_allocator;

    localparam int SLOT_W      = fsla_pkg::SLOT_W;
    localparam int STS_W       = fsla_pkg::STS_W;
    localparam int POOL_MAX    = 254;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 10;

    typedef struct {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        bit                from_held;
    } t_slot_req;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [STS_W-1:0]  sts;
        logic [SLOT_W-1:0] occ;
    } t_slot_rsp;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [SLOT_W-1:0] i_cfg_wr_data;

    fsla_req_if req_if ();
    fsla_rsp_if rsp_if ();

    free_list_slot_allocator #(
        .MAX_SLOTS(POOL_MAX)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_req        (req_if),
        .o_rsp        (rsp_if)
    );

    // allocator mirror
    logic [SLOT_W-1:0] chain_link [POOL_MAX];
    logic [SLOT_W-1:0] head_slot;
    logic [SLOT_W-1:0] used_slots;
    int unsigned       pool_size;

    t_slot_req         pending_reqs [$];
    t_slot_rsp         due_rsps [$];
    logic [SLOT_W-1:0] held_slots [$];

    int  mismatches;
    int  cycles;
    int  send_gap;
    int  recv_gap;
    int  held_pick;
    int  hold_cnt;
    bit  hold_req;
    bit  hold_done;
    bit  steady;
    t_slot_req next_req;

    function automatic void rebuild_chain();
        for (int i = 0; i < POOL_MAX; i++) begin
            chain_link[i] = SLOT_W'(i + 1);
        end
        chain_link[pool_size - 1] = fsla_pkg::END_MARK;
        head_slot  = '0;
        used_slots = '0;
        held_slots.delete();
    endfunction

    function automatic void apply_request(input logic kind,
                                          input logic [SLOT_W-1:0] slot);
        t_slot_rsp r;
        r.slot = '0;
        r.sts  = fsla_pkg::STS_OK;
        if (kind == fsla_pkg::KIND_ALLOC) begin
            if (head_slot >= pool_size) begin
                r.sts = fsla_pkg::STS_FULL;
            end else begin
                r.slot = head_slot;
                held_slots.insert(held_slots.size(), head_slot);
                head_slot = chain_link[head_slot];
                if (used_slots < pool_size) begin
                    used_slots = used_slots + 1'b1;
                end
            end
        end else begin
            if (slot >= pool_size) begin
                r.sts = fsla_pkg::STS_BAD_SLOT;
            end else begin
                chain_link[slot] = head_slot;
                head_slot = slot;
                if (used_slots != 0) begin
                    used_slots = used_slots - 1'b1;
                end
            end
        end
        r.occ = used_slots;
        due_rsps.insert(due_rsps.size(), r);
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_rsp();
        t_slot_rsp want;
        if (due_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected transfer: slot=%0d status=%0d occupied=%0d",
                         rsp_if.slot_out, rsp_if.status, rsp_if.occupied);
            end
            return;
        end
        want = due_rsps.pop_front();
        if (rsp_if.slot_out !== want.slot || rsp_if.status !== want.sts ||
            rsp_if.occupied !== want.occ) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch at %0t: expected slot=%0d status=%0d occupied=%0d",
                         $realtime, want.slot, want.sts, want.occ);
                $display("    got slot=%0d status=%0d occupied=%0d",
                         rsp_if.slot_out, rsp_if.status, rsp_if.occupied);
            end
        end
    endfunction

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || req_if.valid || due_rsps.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_slot_count(input logic [SLOT_W-1:0] value);
        int unsigned v;
        wait_idle();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        v = value;
        if (v < 1) v = 1;
        if (v > POOL_MAX) v = POOL_MAX;
        pool_size = v;
        rebuild_chain();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic add_req(input logic kind, input logic [SLOT_W-1:0] slot);
        t_slot_req q;
        q.kind      = kind;
        q.slot      = slot;
        q.from_held = 1'b0;
        pending_reqs.insert(pending_reqs.size(), q);
    endtask

    task automatic run_phase(input int count, input int alloc_pct);
        t_slot_req q;
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            q.from_held = 1'b0;
            if (r < alloc_pct) begin
                q.kind = fsla_pkg::KIND_ALLOC;
                q.slot = SLOT_W'($urandom_range(0, 255));
            end else if (r < alloc_pct + (100 - alloc_pct) * 8 / 10) begin
                q.kind      = fsla_pkg::KIND_RELEASE;
                q.slot      = SLOT_W'($urandom_range(0, pool_size - 1));
                q.from_held = 1'b1;
            end else begin
                q.kind = fsla_pkg::KIND_RELEASE;
                q.slot = SLOT_W'($urandom_range(0, 255));
            end
            pending_reqs.insert(pending_reqs.size(), q);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid   <= 1'b0;
            req_if.kind    <= fsla_pkg::KIND_ALLOC;
            req_if.slot_in <= '0;
            send_gap = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                apply_request(req_if.kind, req_if.slot_in);
            end
            if (!req_if.valid || req_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    next_req = pending_reqs.pop_front();
                    if (next_req.from_held && held_slots.size() != 0) begin
                        held_pick = $urandom_range(0, held_slots.size() - 1);
                        next_req.slot = held_slots[held_pick];
                        held_slots.delete(held_pick);
                    end
                    req_if.valid   <= 1'b1;
                    req_if.kind    <= next_req.kind;
                    req_if.slot_in <= next_req.slot;
                    send_gap = idle_len();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req && !hold_done) begin
            hold_cnt  <= LONG_HOLD;
            hold_done <= 1'b1;
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                check_rsp();
            end
            if (hold_cnt != 0) begin
                rsp_if.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) begin
                    recv_gap = idle_len();
                end
            end
        end
    end

    initial begin
        int unsigned pools [9];
        int          counts [9];
        int          pcts [9];

        req_if.valid   = 1'b0;
        req_if.kind    = fsla_pkg::KIND_ALLOC;
        req_if.slot_in = '0;
        rsp_if.ready   = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        i_rst_n        = 1'b0;
        mismatches     = 0;
        cycles         = 0;
        hold_req       = 1'b0;
        steady         = 1'b0;
        pool_size      = POOL_MAX;
        rebuild_chain();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset pool: pops, release to head, edge slot, out-of-range releases
        add_req(fsla_pkg::KIND_ALLOC, 8'hFF);
        add_req(fsla_pkg::KIND_ALLOC, 8'h00);
        add_req(fsla_pkg::KIND_ALLOC, 8'hAA);
        add_req(fsla_pkg::KIND_RELEASE, 8'd1);
        add_req(fsla_pkg::KIND_ALLOC, 8'h55);
        add_req(fsla_pkg::KIND_RELEASE, 8'd253);
        add_req(fsla_pkg::KIND_RELEASE, 8'd254);
        add_req(fsla_pkg::KIND_RELEASE, 8'd255);
        add_req(fsla_pkg::KIND_ALLOC, 8'h00);

        // single slot: full, double release, zero-count release, count saturation
        write_slot_count(8'd1);
        add_req(fsla_pkg::KIND_ALLOC, 8'h00);
        add_req(fsla_pkg::KIND_ALLOC, 8'h00);
        add_req(fsla_pkg::KIND_RELEASE, 8'd0);
        add_req(fsla_pkg::KIND_RELEASE, 8'd0);
        add_req(fsla_pkg::KIND_ALLOC, 8'h00);
        add_req(fsla_pkg::KIND_ALLOC, 8'h00);
        add_req(fsla_pkg::KIND_RELEASE, 8'd1);
        add_req(fsla_pkg::KIND_RELEASE, 8'd0);

        // zero clamps to one
        write_slot_count(8'd0);
        add_req(fsla_pkg::KIND_RELEASE, 8'd0);
        add_req(fsla_pkg::KIND_ALLOC, 8'h00);
        add_req(fsla_pkg::KIND_ALLOC, 8'h00);

        // above range clamps to max
        write_slot_count(8'd255);
        add_req(fsla_pkg::KIND_ALLOC, 8'h00);
        add_req(fsla_pkg::KIND_RELEASE, 8'd0);

        pools  = '{254, 1, 2, 255, 0, 9, $urandom_range(3, 40), 254, $urandom_range(1, 254)};
        counts = '{300, 40, 50, 40, 30, 60, 60, 60, 60};
        pcts   = '{85, 55, 50, 50, 55, 60, 60, 45, 50};

        for (int p = 0; p < 9; p++) begin
            write_slot_count(SLOT_W'(pools[p]));
            steady = (p == 2 || p == 6);
            run_phase(counts[p], pcts[p]);
            if (p == 0) begin
                hold_req = 1'b1;
            end
            // sender waits for the pipeline to drain
            wait_idle();
        end

        steady = 1'b0;
        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && due_rsps.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("mismatches: %0d", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
